### hw/rtl/fovpm_pkg.sv
// ----------------------------------------------------------------------------
// fovpm_pkg
// Shared widths, constants and types of the projection matrix pipeline.
// ----------------------------------------------------------------------------
package fovpm_pkg;

  localparam int QW           = 32;         // quotient and result width
  localparam int CW           = 33;         // cordic x, y, z width
  localparam int CORDIC_STEPS = 24;
  localparam int DIV_LAT      = QW + 2;     // prep stage, one cell per bit, output stage

  localparam logic signed [CW-1:0] X_INIT = 33'sd1073741824;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic signed [QW-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] S32_MIN = 32'sh80000000;

  localparam logic signed [CW-1:0] ATAN [CORDIC_STEPS] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021688,  33'sd33543516,  33'sd16775851,  33'sd8388437,
    33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
    33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
    33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
    33'sd1024,      33'sd512,       33'sd256,       33'sd128
  };

  typedef enum logic [1:0] {
    ST_OK,
    ST_ZERO_W,
    ST_ZERO_H,
    ST_FAR_NEAR
  } status_t;

  // sign and overflow of one quotient, carried along the divider cells
  typedef struct packed {
    logic neg;
    logic ovf;
  } div_side_t;

  // result beat, scale_x in the lowest bits
  typedef struct packed {
    status_t            status;
    logic signed [31:0] depth_offset;
    logic signed [31:0] depth_scale;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_x;
  } res_t;

endpackage

### hw/rtl/fovpm_cordic_cell.sv
// ----------------------------------------------------------------------------
// fovpm_cordic_cell
// One rotation step of the tangent cordic, registered.
// ----------------------------------------------------------------------------
module fovpm_cordic_cell import fovpm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[CW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN[STEP];
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN[STEP];
      end
    end
  end

endmodule

### hw/rtl/fovpm_div_cell.sv
// ----------------------------------------------------------------------------
// fovpm_div_cell
// One restoring division step: produces one quotient bit per cycle while en is high.
// ----------------------------------------------------------------------------
module fovpm_div_cell import fovpm_pkg::*; #(
  parameter int BW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [BW-1:0] rem_in,
  input  logic [QW-1:0] lo_in,
  input  logic [BW-1:0] bm_in,
  input  div_side_t     side_in,
  output logic [BW-1:0] rem_out,
  output logic [QW-1:0] lo_out,
  output logic [BW-1:0] bm_out,
  output div_side_t     side_out
);

  logic [BW:0] r2;
  logic [BW:0] diff;
  logic        ge;

  assign r2   = {rem_in, lo_in[QW-1]};
  assign diff = r2 - {1'b0, bm_in};
  assign ge   = r2 >= {1'b0, bm_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[BW-1:0] : r2[BW-1:0];
      lo_out   <= {lo_in[QW-2:0], ge};
      bm_out   <= bm_in;
      side_out <= side_in;
    end
  end

endmodule

### hw/rtl/fovpm_div.sv
// ----------------------------------------------------------------------------
// fovpm_div
// Pipelined signed divider, quotient truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module fovpm_div import fovpm_pkg::*; #(
  parameter int AW = 49,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [QW-1:0] q
);

  localparam int MX = (AW > BW) ? AW : BW;

  logic [AW-1:0] am;
  logic [BW-1:0] bmag;
  div_side_t     side0;

  logic [BW-1:0] rem  [QW+1];
  logic [QW-1:0] lo   [QW+1];
  logic [BW-1:0] bm   [QW+1];
  div_side_t     side [QW+1];

  logic [QW-1:0] qm;
  div_side_t     fs;

  assign am        = a[AW-1] ? ($unsigned(~a) + 1'b1) : $unsigned(a);
  assign bmag      = b[BW-1] ? ($unsigned(~b) + 1'b1) : $unsigned(b);
  assign side0.neg = a[AW-1] ^ b[BW-1];
  // quotient of 2^QW or more cannot be held: saturate at the end
  assign side0.ovf = MX'(am >> QW) >= MX'(bmag);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= BW'(am >> QW);
      lo[0]   <= am[QW-1:0];
      bm[0]   <= bmag;
      side[0] <= side0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    fovpm_div_cell #(.BW(BW)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem[k]),
      .lo_in    (lo[k]),
      .bm_in    (bm[k]),
      .side_in  (side[k]),
      .rem_out  (rem[k+1]),
      .lo_out   (lo[k+1]),
      .bm_out   (bm[k+1]),
      .side_out (side[k+1])
    );
  end

  assign qm = lo[QW];
  assign fs = side[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (fs.neg) begin
        if (fs.ovf || (qm > $unsigned(S32_MIN))) begin
          q <= S32_MIN;
        end else begin
          q <= $signed(-qm);
        end
      end else begin
        if (fs.ovf || qm[QW-1]) begin
          q <= S32_MAX;
        end else begin
          q <= $signed(qm);
        end
      end
    end
  end

endmodule

### hw/rtl/fovpm_delay.sv
// ----------------------------------------------------------------------------
// fovpm_delay
// Shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module fovpm_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < N; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

### hw/rtl/fov_projection_matrix_top.sv
// ----------------------------------------------------------------------------
// fov_projection_matrix_top
// Asymmetric field-of-view perspective projection matrix entries.
// ----------------------------------------------------------------------------
// pipeline: 94 stages plus the output register: input stage, 24 cordic cells,
//   34-stage tangent divider, combine stage, 34-stage matrix divider; the depth
//   path runs alongside
// throughput: one beat per cycle; all stages share one enable that drops only
//   while the skid register holds a beat
// reset clears the stage valid bits, output and skid flags
module fov_projection_matrix_top import fovpm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // near_dist, far_dist, angle_left, angle_up, angle_right, angle_down
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // scale_x, scale_y, offset_x, offset_y, depth_scale, depth_offset, status, zero pad
  output logic [199:0] m_tdata
);

  localparam int TOTAL     = 2 + CORDIC_STEPS + 2 * DIV_LAT;
  localparam int DEPTH_DLY = TOTAL - (3 + DIV_LAT);

  logic             en;
  logic             accept;
  logic [TOTAL-1:0] vld;
  logic             ov, sv, pop, incoming;

  logic [31:0]          near_r;
  logic [31:0]          far_r;
  logic signed [CW-1:0] z0 [4];
  logic signed [QW-1:0] tn [4];

  assign en       = !sv;
  assign s_tready = en && !rst;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], accept};
    end
  end

  // input stage and angle range reduction
  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic signed [17:0]   ang;
    logic signed [33:0]   zq;
    logic signed [33:0]   zr;
    logic signed [CW-1:0] xs [CORDIC_STEPS+1];
    logic signed [CW-1:0] ys [CORDIC_STEPS+1];
    logic signed [CW-1:0] zs [CORDIC_STEPS+1];

    assign ang = s_tdata[64+18*g +: 18];
    assign zq  = {ang[17], ang, 15'b0};

    always_comb begin
      if (zq > HALF_PI_Q30) begin
        zr = zq - PI_Q30;
      end else if (zq < -HALF_PI_Q30) begin
        zr = zq + PI_Q30;
      end else begin
        zr = zq;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z0[g] <= zr[CW-1:0];
      end
    end

    assign xs[0] = X_INIT;
    assign ys[0] = '0;
    assign zs[0] = z0[g];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      fovpm_cordic_cell #(.STEP(i)) u_cell (
        .clk   (clk),
        .en    (en),
        .x_in  (xs[i]),
        .y_in  (ys[i]),
        .z_in  (zs[i]),
        .x_out (xs[i+1]),
        .y_out (ys[i+1]),
        .z_out (zs[i+1])
      );
    end

    fovpm_div #(.AW(CW + 16), .BW(CW)) u_tan (
      .clk (clk),
      .en  (en),
      .a   ({ys[CORDIC_STEPS], 16'b0}),
      .b   (xs[CORDIC_STEPS]),
      .q   (tn[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= s_tdata[31:0];
      far_r  <= s_tdata[63:32];
    end
  end

  // combine stage: widths, sums and zero flags
  logic signed [32:0] w_c, h_c, sw_c, sh_c;
  logic signed [33:0] nsw_c, nsh_c;
  logic signed [32:0] w_r, h_r;
  logic signed [49:0] offa_x, offa_y;
  logic               wz_r, hz_r;

  assign w_c   = 33'(tn[2]) - 33'(tn[0]);
  assign h_c   = 33'(tn[1]) - 33'(tn[3]);
  assign sw_c  = 33'(tn[2]) + 33'(tn[0]);
  assign sh_c  = 33'(tn[1]) + 33'(tn[3]);
  assign nsw_c = -34'(sw_c);
  assign nsh_c = -34'(sh_c);

  always_ff @(posedge clk) begin
    if (en) begin
      w_r    <= w_c;
      h_r    <= h_c;
      offa_x <= {nsw_c, 16'b0};
      offa_y <= {nsh_c, 16'b0};
      wz_r   <= (w_c == '0);
      hz_r   <= (h_c == '0);
    end
  end

  logic signed [QW-1:0] sx, sy, ox, oy;
  logic [1:0]           zf;

  fovpm_div #(.AW(35), .BW(33)) u_sx (
    .clk (clk), .en (en), .a (35'sd8589934592), .b (w_r), .q (sx)
  );
  fovpm_div #(.AW(35), .BW(33)) u_sy (
    .clk (clk), .en (en), .a (35'sd8589934592), .b (h_r), .q (sy)
  );
  fovpm_div #(.AW(50), .BW(33)) u_ox (
    .clk (clk), .en (en), .a (offa_x), .b (w_r), .q (ox)
  );
  fovpm_div #(.AW(50), .BW(33)) u_oy (
    .clk (clk), .en (en), .a (offa_y), .b (h_r), .q (oy)
  );
  fovpm_delay #(.W(2), .N(DIV_LAT)) u_zf (
    .clk (clk), .en (en), .d ({wz_r, hz_r}), .q (zf)
  );

  // depth path
  logic signed [32:0]   dd;
  logic signed [QW-1:0] q_d;
  logic [32:0]          nd_dl;
  logic signed [64:0]   prod;
  logic signed [QW-1:0] q_m;
  logic                 dz_m;
  logic signed [64:0]   pa, tq, nt;
  logic signed [QW-1:0] r_c;
  logic signed [QW-1:0] dq_r, dr_r;
  logic                 dz_r;
  logic [64:0]          dpt;

  assign dd = $signed({1'b0, far_r}) - $signed({1'b0, near_r});

  fovpm_div #(.AW(49), .BW(33)) u_q (
    .clk (clk), .en (en), .a ({1'b0, far_r, 16'b0}), .b (dd), .q (q_d)
  );
  fovpm_delay #(.W(33), .N(DIV_LAT)) u_near (
    .clk (clk), .en (en), .d ({near_r == far_r, near_r}), .q (nd_dl)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= q_d * $signed({1'b0, nd_dl[31:0]});
      q_m  <= q_d;
      dz_m <= nd_dl[32];
    end
  end

  // divide by 2^16 truncating toward zero, negate, saturate
  always_comb begin
    pa = prod + (prod[64] ? 65'sd65535 : 65'sd0);
    tq = pa >>> 16;
    nt = -tq;
    if (nt > 65'(S32_MAX)) begin
      r_c = S32_MAX;
    end else if (nt < 65'(S32_MIN)) begin
      r_c = S32_MIN;
    end else begin
      r_c = nt[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r <= dz_m ? '0 : q_m;
      dr_r <= dz_m ? '0 : r_c;
      dz_r <= dz_m;
    end
  end

  fovpm_delay #(.W(65), .N(DEPTH_DLY)) u_dpt (
    .clk (clk), .en (en), .d ({dz_r, dq_r, dr_r}), .q (dpt)
  );

  // final result assembly
  res_t res_c;

  always_comb begin
    res_c.scale_x      = zf[1] ? '0 : sx;
    res_c.offset_x     = zf[1] ? '0 : ox;
    res_c.scale_y      = zf[0] ? '0 : sy;
    res_c.offset_y     = zf[0] ? '0 : oy;
    res_c.depth_scale  = dpt[63:32];
    res_c.depth_offset = dpt[31:0];
    if (zf[1]) begin
      res_c.status = ST_ZERO_W;
    end else if (zf[0]) begin
      res_c.status = ST_ZERO_H;
    end else if (dpt[64]) begin
      res_c.status = ST_FAR_NEAR;
    end else begin
      res_c.status = ST_OK;
    end
  end

  // output register with skid
  res_t out_r, skid_r;

  assign pop      = ov && m_tready;
  assign incoming = vld[TOTAL-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || pop) begin
      ov <= sv || incoming;
      sv <= 1'b0;
    end else if (incoming) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || pop) begin
      out_r <= sv ? skid_r : res_c;
    end else if (incoming) begin
      skid_r <= res_c;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {6'b0, out_r};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid full while output empty");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst) (sv && m_tready) |=> !sv)
    else $error("skid not drained after output beat");
  a_far_near_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && out_r.status == ST_FAR_NEAR) |-> (out_r.depth_scale == '0 && out_r.depth_offset == '0))
    else $error("depth terms not cleared for far equal to near");
  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    (ov && out_r.status == ST_ZERO_W) |-> (out_r.scale_x == '0 && out_r.offset_x == '0))
    else $error("horizontal terms not cleared for zero width");

endmodule

### tb/fov_projection_matrix_top_test.sv
// ----------------------------------------------------------------------------
// fov_projection_matrix_top_test
// Streams clip distances and half-angles into the projection matrix block and
// checks every result beat against a bit-exact cordic and divider predictor.
// ----------------------------------------------------------------------------
module fov_projection_matrix_top_test import fovpm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint sx, sy, ox, oy, q, r;
    status_t st;
  } matrix_t;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // q16.16 tangent of a q3.15 angle
  function automatic longint tangent_q16(logic signed [17:0] ang);
    longint z, x, y, dx, dy;
    z = longint'(ang) * 32768;
    x = 1073741824;
    y = 0;
    if (z > longint'(HALF_PI_Q30)) z -= longint'(PI_Q30);
    else if (z < -longint'(HALF_PI_Q30)) z += longint'(PI_Q30);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN[i]);
      end
    end
    if (x == 0) return (y < 0) ? -64'sd2147483648 : 64'sd2147483647;
    return clamp32((y * 65536) / x);
  endfunction

  function automatic matrix_t project(logic [135:0] d);
    matrix_t m;
    longint nr, fr, tl, tu, tr, td, w, h, dd;
    nr = longint'(d[31:0]);
    fr = longint'(d[63:32]);
    tl = tangent_q16(d[81:64]);
    tu = tangent_q16(d[99:82]);
    tr = tangent_q16(d[117:100]);
    td = tangent_q16(d[135:118]);
    w = tr - tl; h = tu - td; dd = fr - nr;
    m = '{0, 0, 0, 0, 0, 0, ST_OK};
    if (w != 0) begin
      m.sx = clamp32(64'sd8589934592 / w);
      m.ox = clamp32((-(tr + tl) * 65536) / w);
    end else m.st = ST_ZERO_W;
    if (h != 0) begin
      m.sy = clamp32(64'sd8589934592 / h);
      m.oy = clamp32((-(tu + td) * 65536) / h);
    end else if (m.st == ST_OK) m.st = ST_ZERO_H;
    if (dd != 0) begin
      m.q = clamp32((fr * 65536) / dd);
      m.r = clamp32(-((m.q * nr) / 65536));
    end else if (m.st == ST_OK) m.st = ST_FAR_NEAR;
    return m;
  endfunction

  class matrix_scoreboard;
    res_t pending[$];
    int errors, checked;

    function void note_input(logic [135:0] d);
      matrix_t m;
      res_t r;
      m = project(d);
      r.scale_x = m.sx[31:0];
      r.scale_y = m.sy[31:0];
      r.offset_x = m.ox[31:0];
      r.offset_y = m.oy[31:0];
      r.depth_scale = m.q[31:0];
      r.depth_offset = m.r[31:0];
      r.status = m.st;
      pending.push_back(r);
    endfunction

    function void check_result(logic [199:0] d);
      res_t got, want;
      got = res_t'(d[193:0]);
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", d);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want || d[199:194] !== 6'd0) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch", checked);
          $display("  exp sx %h sy %h ox %h oy %h q %h r %h st %0d", want.scale_x,
                   want.scale_y, want.offset_x, want.offset_y, want.depth_scale,
                   want.depth_offset, want.status);
          $display("  got sx %h sy %h ox %h oy %h q %h r %h st %0d pad %h", got.scale_x,
                   got.scale_y, got.offset_x, got.offset_y, got.depth_scale,
                   got.depth_offset, got.status, d[199:194]);
        end
      end
    endfunction
  endclass

  localparam int LATENCY = 95;
  localparam int WATCHDOG = 4000;
  localparam int RANDOM_BEATS = 1700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [199:0] m_tdata;

  matrix_scoreboard sb = new();
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit hold_sink = 1'b0;
  int idle_cycles = 0;
  int sent = 0;

  always #6 clk = ~clk;

  fov_projection_matrix_top uut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_sink) m_tready <= 1'b0;
    else m_tready <= sink_calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one beat, with random gaps ahead of it unless calm
  task automatic send_beat(logic [135:0] d);
    while (!src_calm && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  function automatic logic [17:0] pick_angle();
    case ($urandom_range(5))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, 51471));          // up to about pi/2
      2: return 18'(-$signed(18'($urandom_range(0, 51471))));
      3: return 18'($urandom_range(51465, 51480));      // around pi/2
      4: return 18'(-$signed(18'($urandom_range(51465, 51480))));
      default: return 18'($urandom_range(0, 40000) - 20000);
    endcase
  endfunction

  function automatic logic [135:0] pack_beat(logic [31:0] nr, logic [31:0] fr,
      logic [17:0] al, logic [17:0] au, logic [17:0] ar, logic [17:0] ad);
    return {ad, ar, au, al, fr, nr};
  endfunction

  task automatic send_random();
    logic [31:0] nr, fr;
    logic [17:0] al, au, ar, ad;
    nr = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
    case ($urandom_range(7))
      0: fr = nr;
      1: fr = $urandom;
      2: fr = nr + $urandom_range(1, 4);
      default: fr = nr + $urandom_range(0, 32'h0100_0000);
    endcase
    al = pick_angle();
    ar = $urandom_range(9) == 0 ? al : pick_angle();
    au = pick_angle();
    ad = $urandom_range(9) == 0 ? au : pick_angle();
    send_beat(pack_beat(nr, fr, al, au, ar, ad));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: symmetric, extremes, faults, far below near, cosine near zero
    send_beat(pack_beat(32'h0001_0000, 32'h0064_0000, -18'sd25736, 18'sd25736,
                        18'sd25736, -18'sd25736));
    send_beat(pack_beat(32'h0000_0000, 32'hffff_ffff, 18'h20000, 18'h1ffff,
                        18'h1ffff, 18'h20000));
    send_beat(pack_beat(32'hffff_ffff, 32'h0000_0000, 18'h1ffff, 18'h20000,
                        18'h20000, 18'h1ffff));
    send_beat(pack_beat(32'h0001_0000, 32'h0002_0000, 18'sd100, 18'sd200,
                        18'sd100, -18'sd200));
    send_beat(pack_beat(32'h0001_0000, 32'h0002_0000, -18'sd300, 18'sd50,
                        18'sd300, 18'sd50));
    send_beat(pack_beat(32'h0003_0000, 32'h0003_0000, -18'sd300, 18'sd50,
                        18'sd300, -18'sd50));
    send_beat(pack_beat(32'h0003_0000, 32'h0003_0000, 18'sd7, 18'sd9, 18'sd7, 18'sd9));
    send_beat(pack_beat(32'h0005_0000, 32'h0001_0000, 18'sd51472, -18'sd51472,
                        18'sd51471, -18'sd51471));
    send_beat(pack_beat(32'h0000_0001, 32'h0000_0002, 18'sd51473, 18'sd102944,
                        -18'sd51473, -18'sd102944));
    send_beat(pack_beat(32'h0000_0000, 32'h0000_0000, 18'sd0, 18'sd0, 18'sd0, 18'sd0));
    send_beat(pack_beat(32'haaaa_aaaa, 32'h5555_5555, 18'h2aaaa, 18'h15555,
                        18'h15555, 18'h2aaaa));
    send_beat(pack_beat(32'h7fff_ffff, 32'h8000_0000, -18'sd1, 18'sd1, 18'sd1, -18'sd1));

    // back pressure: sink held off while the source keeps pushing
    src_calm = 1'b1;
    hold_sink = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      repeat (200) send_random();
    join

    src_calm = 1'b0;
    for (int i = 0; i < RANDOM_BEATS - 200; i++) begin
      if (i == 600) begin
        src_calm = 1'b1;
        sink_calm = 1'b1;
      end
      if (i == 900) begin
        src_calm = 1'b0;
        sink_calm = 1'b0;
      end
      send_random();
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d beats sent, %0d results checked: angle extremes, pole crossings,",
             sent, sb.checked);
    $display("zero width, zero height, equal clip planes and long output stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
